// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masked.
`define NSCD_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Next-cycle implication, reset masked.
`define NSCD_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== sv/nscd_pkg.sv =====
`timescale 1ns / 1ps
package nscd_pkg;
  localparam int RW            = 64;
  localparam int PW            = 33;
  localparam int NBW           = 22;
  localparam int DRIVE_BITS    = 24;
  localparam int DRIVE_FRAC    = 16;
  localparam int ROOT_IN_FRAC  = 32;
  localparam int ROOT_OUT_FRAC = 16;
  localparam int ROOT_STEPS    = 32;
  localparam int LANES         = 2;
  localparam logic [DRIVE_BITS-1:0] DRIVE_RESET = 24'd65536;

  typedef logic [LANES-1:0][RW-1:0] root_lanes_t;
endpackage

// ===== sv/nscd_if.sv =====
`timescale 1ns / 1ps
interface nscd_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source (output valid, sample_in, input ready);
  modport sink   (input valid, sample_in, output ready);
endinterface

interface nscd_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;
  modport source (output valid, sample_out, saturated, input ready);
  modport sink   (input valid, sample_out, saturated, output ready);
endinterface

interface nscd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [nscd_pkg::DRIVE_BITS-1:0]     drive_gain;
  modport source (output valid, drive_gain, input ready);
  modport sink   (input valid, drive_gain, output ready);
endinterface

// ===== sv/nscd_sqrt_cell.sv =====
`timescale 1ns / 1ps
module nscd_sqrt_cell #(
  parameter int STEP = 0,
  parameter int TW   = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_i,
  input  nscd_pkg::root_lanes_t rem_i,
  input  nscd_pkg::root_lanes_t root_i,
  input  logic [TW-1:0]        tag_i,
  output logic                 valid_o,
  output nscd_pkg::root_lanes_t rem_o,
  output nscd_pkg::root_lanes_t root_o,
  output logic [TW-1:0]        tag_o
);
  localparam logic [nscd_pkg::RW-1:0] BIT = nscd_pkg::RW'(1) << (62 - 2 * STEP);

  logic                  valid_r;
  nscd_pkg::root_lanes_t rem_r, rem_nxt, root_r, root_nxt;
  logic [TW-1:0]         tag_r;
  logic [nscd_pkg::RW-1:0] trial;

  always_comb begin
    trial = '0;
    for (int l = 0; l < nscd_pkg::LANES; l++) begin
      trial = root_i[l] + BIT;
      if (rem_i[l] >= trial) begin
        rem_nxt[l]  = rem_i[l] - trial;
        root_nxt[l] = (root_i[l] >> 1) + BIT;
      end else begin
        rem_nxt[l]  = rem_i[l];
        root_nxt[l] = root_i[l] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      tag_r  <= tag_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign root_o  = root_r;
  assign tag_o   = tag_r;
endmodule

// ===== sv/nscd_div_cell.sv =====
`timescale 1ns / 1ps
module nscd_div_cell #(
  parameter int K  = 0,
  parameter int NW = 58,
  parameter int QW = 24,
  parameter int TW = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      valid_i,
  input  logic [NW-1:0]             rem_i,
  input  logic [nscd_pkg::PW-1:0]   p_i,
  input  logic [QW-1:0]             q_i,
  input  logic [TW-1:0]             tag_i,
  output logic                      valid_o,
  output logic [NW-1:0]             rem_o,
  output logic [nscd_pkg::PW-1:0]   p_o,
  output logic [QW-1:0]             q_o,
  output logic [TW-1:0]             tag_o
);
  logic                    valid_r;
  logic [NW-1:0]           rem_r, rem_nxt, dsr;
  logic [nscd_pkg::PW-1:0] p_r;
  logic [QW-1:0]           q_r, q_nxt;
  logic [TW-1:0]           tag_r;

  always_comb begin
    dsr     = NW'(p_i) << K;
    rem_nxt = rem_i;
    q_nxt   = q_i;
    if (rem_i >= dsr) begin
      rem_nxt  = rem_i - dsr;
      q_nxt[K] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      p_r   <= p_i;
      q_r   <= q_nxt;
      tag_r <= tag_i;
    end
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign p_o     = p_r;
  assign q_o     = q_r;
  assign tag_o   = tag_r;
endmodule

// ===== sv/normalized_soft_clip_drive.sv =====
`timescale 1ns / 1ps
// Soft-clip waveshaper with drive and renormalisation: y = x*(1+sqrt(1+d))/(1+sqrt(1+|x|*d)).
// Channels: in_ch carries sample_in (signed Q3.20 by default), out_ch carries
// sample_out and saturated, cfg_ch writes drive_gain (unsigned Q8.16, 0 acts as one LSB).
// cfg_ch is always ready; write it only while no item is in flight.
// Throughput: one item per cycle while out_ch is not stalled. The pipeline is
// the registers s0, s1 and s2, a row of 32 square-root cells (one result bit
// each), s3, s4, SAMPLE_BITS divider cells and the output register.
// The whole row advances together; when out_ch is held valid and not ready,
// every cell holds and in_ch.ready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the row and sets drive_gain to unity.
// saturated marks results clamped to the signed sample range.
module normalized_soft_clip_drive #(
  parameter int SAMPLE_BITS      = 24,
  parameter int SAMPLE_FRAC_BITS = 20
) (
  input  logic   clk,
  input  logic   rst_n,
  nscd_in_if.sink    in_ch,
  nscd_out_if.source out_ch,
  nscd_cfg_if.sink   cfg_ch
);
  localparam int SB  = SAMPLE_BITS;
  localparam int AF  = SAMPLE_FRAC_BITS + nscd_pkg::DRIVE_FRAC;
  localparam int SHL = (AF < nscd_pkg::ROOT_IN_FRAC) ? (nscd_pkg::ROOT_IN_FRAC - AF) : 0;
  localparam int SHR = (AF > nscd_pkg::ROOT_IN_FRAC) ? (AF - nscd_pkg::ROOT_IN_FRAC) : 0;
  localparam int MW  = SB + nscd_pkg::DRIVE_BITS;
  localparam int XW  = SB + nscd_pkg::NBW;
  localparam int NW  = SB + nscd_pkg::PW + 1;
  localparam int RS  = nscd_pkg::ROOT_STEPS;
  localparam int RW  = nscd_pkg::RW;
  localparam int PW  = nscd_pkg::PW;

  logic en;
  logic [nscd_pkg::DRIVE_BITS-1:0] drive_r, d_eff;

  logic          s0_valid_r;
  logic [SB-1:0] s0_smp_r, mag0;
  logic          neg0;

  logic          s1_valid_r, s1_neg_r;
  logic [SB-1:0] s1_mag_r;
  logic [MW-1:0] s1_prod_r;

  logic [RW-1:0] a_sum, a_root;

  logic                  sq_valid [0:RS];
  nscd_pkg::root_lanes_t sq_rem   [0:RS];
  nscd_pkg::root_lanes_t sq_root  [0:RS];
  logic [SB:0]           sq_tag   [0:RS];

  logic                  s2_valid_r;
  nscd_pkg::root_lanes_t s2_rem_r;
  logic [SB:0]           s2_tag_r;

  logic [PW-1:0]           p3;
  logic [nscd_pkg::NBW-1:0] n3;
  logic          s3_valid_r, s3_neg_r;
  logic [PW-1:0] s3_p_r;
  logic [XW-1:0] s3_prod_r;

  logic [NW-1:0] num4;
  logic          s4_valid_r;
  logic [NW-1:0] s4_num_r;
  logic [PW-1:0] s4_p_r;
  logic [1:0]    s4_tag_r;

  logic          dv_valid [0:SB];
  logic [NW-1:0] dv_rem   [0:SB];
  logic [PW-1:0] dv_p     [0:SB];
  logic [SB-1:0] dv_q     [0:SB];
  logic [1:0]    dv_tag   [0:SB];

  logic          out_valid_r, out_sat_r, out_sat_nxt;
  logic [SB-1:0] out_smp_r, out_smp_nxt;
  logic [SB:0]   q_ext;
  logic          q_neg, q_ovf;

  assign en           = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= nscd_pkg::DRIVE_RESET;
    end else if (cfg_ch.valid) begin
      drive_r <= cfg_ch.drive_gain;
    end
  end

  assign d_eff = (drive_r == '0) ? nscd_pkg::DRIVE_BITS'(1) : drive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r  <= in_ch.valid;
      s1_valid_r  <= s0_valid_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= sq_valid[RS];
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= dv_valid[SB];
    end
  end

  assign neg0 = s0_smp_r[SB-1];
  assign mag0 = neg0 ? (SB'(0) - s0_smp_r) : s0_smp_r;

  assign a_sum  = (RW'(1) << AF) + RW'(s1_prod_r);
  assign a_root = (a_sum << SHL) >> SHR;

  assign p3 = PW'(1 << nscd_pkg::ROOT_OUT_FRAC) + PW'(sq_root[RS][0]);
  assign n3 = nscd_pkg::NBW'(1 << nscd_pkg::ROOT_OUT_FRAC)
            + nscd_pkg::NBW'(sq_root[RS][1]);

  assign num4 = NW'(s3_prod_r) + NW'(s3_p_r >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      s0_smp_r    <= in_ch.sample_in;
      s1_neg_r    <= neg0;
      s1_mag_r    <= mag0;
      s1_prod_r   <= MW'(mag0) * MW'(d_eff);
      s2_rem_r[0] <= a_root;
      s2_rem_r[1] <= (RW'(1) << nscd_pkg::ROOT_IN_FRAC)
                   + (RW'(d_eff) << (nscd_pkg::ROOT_IN_FRAC - nscd_pkg::DRIVE_FRAC));
      s2_tag_r    <= {s1_neg_r, s1_mag_r};
      s3_neg_r    <= sq_tag[RS][SB];
      s3_p_r      <= p3;
      s3_prod_r   <= XW'(sq_tag[RS][SB-1:0]) * XW'(n3);
      s4_num_r    <= num4;
      s4_p_r      <= s3_p_r;
      s4_tag_r    <= {s3_neg_r, (num4 >= (NW'(s3_p_r) << SB))};
      out_smp_r   <= out_smp_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

  assign sq_valid[0] = s2_valid_r;
  assign sq_rem[0]   = s2_rem_r;
  assign sq_root[0]  = '0;
  assign sq_tag[0]   = s2_tag_r;

  for (genvar i = 0; i < RS; i++) begin : g_root
    nscd_sqrt_cell #(.STEP(i), .TW(SB + 1)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (sq_valid[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .tag_i   (sq_tag[i]),
      .valid_o (sq_valid[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .tag_o   (sq_tag[i+1])
    );
  end

  assign dv_valid[0] = s4_valid_r;
  assign dv_rem[0]   = s4_num_r;
  assign dv_p[0]     = s4_p_r;
  assign dv_q[0]     = '0;
  assign dv_tag[0]   = s4_tag_r;

  for (genvar i = 0; i < SB; i++) begin : g_div
    nscd_div_cell #(.K(SB - 1 - i), .NW(NW), .QW(SB), .TW(2)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (dv_valid[i]),
      .rem_i   (dv_rem[i]),
      .p_i     (dv_p[i]),
      .q_i     (dv_q[i]),
      .tag_i   (dv_tag[i]),
      .valid_o (dv_valid[i+1]),
      .rem_o   (dv_rem[i+1]),
      .p_o     (dv_p[i+1]),
      .q_o     (dv_q[i+1]),
      .tag_o   (dv_tag[i+1])
    );
  end

  always_comb begin
    q_neg = dv_tag[SB][1];
    q_ovf = dv_tag[SB][0];
    q_ext = {1'b0, dv_q[SB]};
    out_sat_nxt = 1'b0;
    if (q_neg) begin
      if (q_ovf || q_ext > ((SB + 1)'(1) << (SB - 1))) begin
        q_ext       = (SB + 1)'(1) << (SB - 1);
        out_sat_nxt = 1'b1;
      end
      out_smp_nxt = SB'((SB + 1)'(0) - q_ext);
    end else begin
      if (q_ovf || q_ext > (((SB + 1)'(1) << (SB - 1)) - (SB + 1)'(1))) begin
        q_ext       = ((SB + 1)'(1) << (SB - 1)) - (SB + 1)'(1);
        out_sat_nxt = 1'b1;
      end
      out_smp_nxt = SB'(q_ext);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_smp_r;
  assign out_ch.saturated  = out_sat_r;
endmodule

// ===== sv/nscd_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nscd_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] sample_out,
  input logic                   saturated
);
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  `NSCD_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(saturated), "stalled result changed")
  `NSCD_ASSERT_NOW(a_sat_rail, clk, rst_n, out_valid && saturated, sample_out == S_MAX || sample_out == S_MIN, "saturated result off the rail")
  `NSCD_ASSERT_NOW(a_ready_free, clk, rst_n, !out_valid, in_ready, "input blocked with empty output")
  `NSCD_ASSERT_NOW(a_stall_ready, clk, rst_n, out_valid && !out_ready, !in_ready, "input taken during output stall")
endmodule

bind normalized_soft_clip_drive nscd_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_nscd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .sample_out (out_ch.sample_out),
  .saturated  (out_ch.saturated)
);
